/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the bounded stack.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies b on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// Condition a implies b on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`endif

/* rtl/bsd_pkg.sv */
// Shared constants and types for the bounded stack with dump.
// No dependencies.
package bsd_pkg;

  localparam int VAL_W       = 64;
  localparam int CMD_W       = 3;
  localparam int CAP_W       = 7;
  localparam int STACK_DEPTH = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_PUSH        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP         = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP_TOP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_BOTTOM = 3'd4;

  // Ring movement for the whole row of cells.
  typedef struct packed {
    logic dn;  // take the value of the previous cell
    logic up;  // take the value of the next cell
  } shift_t;

endpackage

/* rtl/bsd_cell.sv */
// One storage cell of the stack ring.
// Depends on bsd_pkg.
module bsd_cell (
  input  logic                       clk,
  input  bsd_pkg::shift_t            ctl,
  input  logic [bsd_pkg::VAL_W-1:0]  prev_data,
  input  logic [bsd_pkg::VAL_W-1:0]  next_data,
  output logic [bsd_pkg::VAL_W-1:0]  data
);
  import bsd_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    priority if (ctl.dn) begin
      data_nxt = prev_data;
    end else if (ctl.up) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* rtl/bounded_stack_with_dump_unit.sv */
// Top level of the bounded LIFO stack with peek and dumps.
// Depends on bsd_pkg, bsd_cell and assert_macros.svh.
//
// The stack is a ring of DEPTH cells with the top entry always in cell 0.
// Push shifts the ring down and pop rotates it up; push, pop and peek are
// taken back to back, a peek only while the output register is free. A
// dump walks the ring: DEPTH steps top first, DEPTH+1 bottom first, one
// ring step a cycle unless a beat waits on out_ready, independent of how
// many entries are stored; input is held off for the whole dump. Dumps
// and peeks on an empty stack give no beat. The capacity register caps
// the entry count at min(capacity, DEPTH); write it only while the block is idle.
module bounded_stack_with_dump_unit #(
  parameter int DEPTH = bsd_pkg::STACK_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bsd_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bsd_pkg::CMD_W-1:0]  in_cmd,
  input  logic [bsd_pkg::VAL_W-1:0]  in_push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsd_pkg::VAL_W-1:0]  out_item_value,
  output logic                       out_last_item
);
  import bsd_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DTOP = 2'd1;
  localparam logic [1:0] ST_DBOT = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r;

  logic [VAL_W-1:0] cell_q [DEPTH];
  logic [VAL_W-1:0] cell0_in;
  shift_t           shift;
  logic             sel_push;
  logic [CW-1:0]    limit;
  logic             out_free, in_fire, emit_now, adv, load_out, load_last;
  logic [VAL_W-1:0] load_value;

  // Row of cells; the last cell wraps round to the first.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] prev_d, next_d;
    if (i == 0) begin : g_first
      assign prev_d = cell0_in;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_q[0];
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end
    bsd_cell u_cell (
      .clk       (clk),
      .ctl       (shift),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  assign cell0_in = sel_push ? in_push_value : cell_q[DEPTH-1];

  assign limit = (cap_r >= CAP_W'(DEPTH)) ? CW'(DEPTH) : cap_r[CW-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == ST_IDLE) && (out_free || in_cmd != CMD_PEEK);
  assign in_fire  = in_valid && in_ready;

  // Does the current dump step put out a beat?
  always_comb begin
    unique case (st_r)
      ST_DTOP: emit_now = step_r < cnt_r;
      ST_DBOT: emit_now = ((CW+1)'(step_r) + (CW+1)'(cnt_r)) > (CW+1)'(DEPTH);
      default: emit_now = 1'b0;
    endcase
  end

  assign adv = (st_r != ST_IDLE) && (!emit_now || out_free);

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    shift      = '0;
    sel_push   = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    load_value = cell_q[0];
    unique case (st_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          unique case (in_cmd)
            CMD_PUSH: begin
              if (cnt_r < limit) begin
                shift.dn = 1'b1;
                sel_push = 1'b1;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            CMD_POP: begin
              if (cnt_r != '0) begin
                shift.up = 1'b1;
                cnt_nxt  = cnt_r - CW'(1);
              end
            end
            CMD_PEEK: begin
              load_out  = cnt_r != '0;
              load_last = 1'b1;
            end
            CMD_DUMP_TOP: begin
              if (cnt_r != '0) st_nxt = ST_DTOP;
            end
            CMD_DUMP_BOTTOM: begin
              if (cnt_r != '0) st_nxt = ST_DBOT;
            end
            default: ;
          endcase
        end
      end
      ST_DTOP: begin
        if (adv) begin
          shift.up  = 1'b1;
          load_out  = emit_now;
          load_last = step_r == cnt_r - CW'(1);
          step_nxt  = step_r + CW'(1);
          if (step_r == CW'(DEPTH - 1)) st_nxt = ST_IDLE;
        end
      end
      ST_DBOT: begin
        // Walk the ring downward; the bottom entry reaches cell 0 first.
        if (adv) begin
          load_out  = emit_now;
          load_last = step_r == CW'(DEPTH);
          step_nxt  = step_r + CW'(1);
          if (step_r == CW'(DEPTH)) begin
            st_nxt = ST_IDLE;
          end else begin
            shift.dn = 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= load_value;
      out_last_r  <= load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = out_value_r;
  assign out_last_item  = out_last_r;

  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "count above depth")
  `ASSERT_IMPLIES(a_dump_nonempty, clk, rst_n, st_r != ST_IDLE, cnt_r != '0, "dump on empty")
  `ASSERT_IMPLIES(a_dump_block, clk, rst_n, st_r != ST_IDLE, !in_ready, "input taken in dump")
  `ASSERT_NEXT(a_dump_cnt, clk, rst_n, st_r != ST_IDLE, $stable(cnt_r), "count moved in dump")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for bounded_stack_with_dump_unit: push, pop, peek and both dumps,
// predicted by an in-bench stack and checked beat by beat.
// Depends on bsd_pkg and the RTL of the unit.
module tb_top;
  import bsd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE = STACK_DEPTH + 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } stack_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } entry_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_PUSH;
  logic [VAL_W-1:0] in_push_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_item_value;
  logic             out_last_item;

  // stack predictor state
  logic [VAL_W-1:0] stk_mem [STACK_DEPTH];
  int               stk_count = 0;
  int               stk_cap = CAP_RESET;

  stack_cmd_t  pend_q[$];
  entry_beat_t expected_entries[$];

  int send_idle_pct = 36;
  int recv_idle_pct = 56;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int beats_seen = 0;
  int err_count = 0;
  int cycle_count = 0;

  bounded_stack_with_dump_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item_value(out_item_value),
    .out_last_item (out_last_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic stack_apply(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value);
    int n;
    int lim;
    n = stk_count;
    lim = (stk_cap < STACK_DEPTH) ? stk_cap : STACK_DEPTH;
    case (cmd)
      CMD_PUSH: begin
        if (n < lim) begin
          stk_mem[n] = value;
          stk_count = n + 1;
        end
      end
      CMD_POP: begin
        if (n > 0) stk_count = n - 1;
      end
      CMD_PEEK: begin
        if (n > 0) expected_entries.push_back(entry_beat_t'{stk_mem[n-1], 1'b1});
      end
      CMD_DUMP_TOP: begin
        for (int i = n; i > 0; i--)
          expected_entries.push_back(entry_beat_t'{stk_mem[i-1], i == 1});
      end
      CMD_DUMP_BOTTOM: begin
        for (int i = 0; i < n; i++)
          expected_entries.push_back(entry_beat_t'{stk_mem[i], i == n - 1});
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // driver: one command beat held until taken
  always @(posedge clk) begin : drv
    stack_cmd_t nxt;
    logic       busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        stack_apply(in_cmd, in_push_value);
        cmds_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          in_valid      <= 1'b1;
          in_cmd        <= nxt.cmd;
          in_push_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: each result beat against the oldest expectation
  always @(posedge clk) begin : mon
    entry_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected beat, value", out_item_value, '0);
        end else begin
          want = expected_entries.pop_front();
          if (out_item_value !== want.value)
            report_mismatch("item_value", out_item_value, want.value);
          if (out_last_item !== want.last)
            report_mismatch("last_item", {63'd0, out_last_item}, {63'd0, want.last});
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
               expected_entries.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value);
    pend_q.push_back(stack_cmd_t'{cmd, value});
    cmds_queued++;
  endtask

  // a query or an unused code
  task automatic queue_query();
    int r;
    r = $urandom_range(99);
    if (r < 35)      queue_cmd(CMD_PEEK, rand_word());
    else if (r < 60) queue_cmd(CMD_DUMP_TOP, rand_word());
    else if (r < 85) queue_cmd(CMD_DUMP_BOTTOM, rand_word());
    else queue_cmd(CMD_UNUSED_FIRST
                   + CMD_W'($urandom_range(CMD_UNUSED_LAST - CMD_UNUSED_FIRST)),
                   rand_word());
  endtask

  task automatic queue_mix(input int count, input int push_pct, input int pop_pct);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < push_pct)                queue_cmd(CMD_PUSH, rand_word());
      else if (r < push_pct + pop_pct) queue_cmd(CMD_POP, rand_word());
      else                             queue_query();
    end
  endtask

  // sender holds off until every command is taken and every beat is back, then a settling wait
  task automatic drain();
    while (cmds_accepted != cmds_queued || expected_entries.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    stk_cap = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pushes;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack, unused codes, extreme values, capacity at reset
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_PEEK, '0);
    queue_cmd(CMD_DUMP_TOP, '0);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    queue_cmd(CMD_UNUSED_FIRST, '1);
    queue_cmd(CMD_UNUSED_LAST, 64'h5a5a_5a5a_5a5a_5a5a);
    queue_cmd(CMD_PUSH, '0);
    queue_cmd(CMD_PUSH, '1);
    queue_cmd(CMD_PUSH, 64'h0123_4567_89ab_cdef);
    queue_cmd(CMD_PEEK, '0);
    queue_cmd(CMD_DUMP_TOP, '0);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_PEEK, '0);
    drain();

    // capacity one, set below the current count first
    write_capacity(7'd1);
    queue_cmd(CMD_PUSH, 64'hdead_beef_0000_0001);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_PUSH, 64'h8000_0000_0000_0001);
    queue_cmd(CMD_PUSH, 64'h7fff_ffff_ffff_fffe);
    queue_cmd(CMD_PEEK, '0);
    queue_cmd(CMD_DUMP_TOP, '0);
    queue_cmd(CMD_POP, '0);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    drain();

    // capacity zero: every push dropped
    write_capacity(7'd0);
    queue_cmd(CMD_PUSH, '1);
    queue_cmd(CMD_PEEK, '0);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    drain();

    // capacity beyond the store: fill to the top and push past it
    write_capacity(7'd127);
    pushes = 0;
    while (pushes < STACK_DEPTH + 2) begin
      if ($urandom_range(99) < 6) begin
        queue_query();
      end else begin
        queue_cmd(CMD_PUSH, rand_word());
        pushes++;
      end
    end
    queue_cmd(CMD_DUMP_TOP, '0);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    drain();

    // capacity cut below a full stack, then a pop-heavy mix
    send_idle_pct = 56;
    recv_idle_pct = 36;
    write_capacity(7'd60);
    queue_mix(14, 30, 55);
    queue_cmd(CMD_DUMP_BOTTOM, '0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(7'd64);
    queue_mix(10, 45, 30);
    queue_cmd(CMD_DUMP_TOP, '0);
    drain();

    $display("Ran %0d commands over capacities 64, 1, 0, 127, 60 and 64; %0d result beats",
             cmds_accepted, beats_seen);
    $display("checked, %0d mismatches", err_count);
    if (err_count == 0 && expected_entries.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
